// ===== rtl/isms_pkg.sv =====
// Shared types and codes for the interval set merge/insert block.
`timescale 1ns / 1ps
`default_nettype none

package isms_pkg;

  // Item kinds carried on in_tuser
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  // What a cell loads on the next clock
  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_LOAD_NEW  = 2'd1,
    CELL_TAKE_PREV = 2'd2,
    CELL_TAKE_NEXT = 2'd3
  } cell_op_t;

  // Position of a stored range against the pending range
  typedef struct packed {
    logic low;   // entry ends before the pending range starts
    logic high;  // entry starts after the pending range ends
  } cell_flags_t;

endpackage

`default_nettype wire

// ===== rtl/interval_set_merge_insert.sv =====
// Top level: sorted range table with merge on insert, built as a chain of cells.
`timescale 1ns / 1ps
`default_nettype none

// Keeps up to TABLE_DEPTH disjoint inclusive ranges sorted by start, one per cell
// of a shift chain. A read word moves from the idle to the busy state on
// acceptance, and its result is registered once the output register is free. An
// insert word stays in the busy state while stored ranges overlap it: every cell
// compares its range against the pending one in parallel, and the chain compacts
// out one absorbed range per cycle before the widened range is shifted into its
// sorted slot and its result is registered. One word is processed at a time; a
// new word is taken while the previous result still sits in the output register,
// and a word that finishes while that register is still held waits until it is
// taken.
// The table needs no clearing after reset; only entries below the count are read.
module interval_set_merge_insert import isms_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int INDEX_BITS  = 31,
  localparam int CNT_W    = $clog2(TABLE_DEPTH + 1),
  localparam int RIDX_W   = $clog2(TABLE_DEPTH),
  localparam int IN_W     = 2 * INDEX_BITS + RIDX_W,
  localparam int IN_TD_W  = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W    = 2 + CNT_W + 1 + 2 * INDEX_BITS,
  localparam int OUT_TD_W = ((OUT_W + 7) / 8) * 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  // low to high: range_start, range_end, read_index
  input  wire logic [IN_TD_W-1:0]  in_tdata,
  // mode
  input  wire logic                in_tuser,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  // low to high: status, entry_count, entry_valid, entry_start, entry_end
  output logic      [OUT_TD_W-1:0] out_tdata
);

  typedef enum logic {
    S_IDLE,
    S_BUSY
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TD_W-1:0]     out_tdata_r, out_tdata_nxt;
  logic                    mode_r, mode_nxt;
  logic [INDEX_BITS-1:0]   pend_start_r, pend_start_nxt;
  logic [INDEX_BITS-1:0]   pend_end_r, pend_end_nxt;
  logic [RIDX_W-1:0]       ridx_r, ridx_nxt;

  logic [INDEX_BITS-1:0]   cell_start [TABLE_DEPTH];
  logic [INDEX_BITS-1:0]   cell_end   [TABLE_DEPTH];
  cell_flags_t             cell_flags [TABLE_DEPTH];
  cell_op_t                cell_op    [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]  cell_valid;
  logic [TABLE_DEPTH-1:0]  overlap;
  logic [TABLE_DEPTH-1:0]  first_ov;
  logic [INDEX_BITS-1:0]   sel_start, sel_end;

  logic                    in_fire;
  logic                    out_free;
  logic                    range_bad;
  logic                    any_ov;
  logic                    table_full;
  logic                    remove_step;
  logic                    res_ready;
  logic                    commit;
  logic                    do_insert;
  status_t                 res_status;
  logic                    rd_hit;
  logic [INDEX_BITS-1:0]   rd_start, rd_end;

  // ---------------------------------------------------------------- cell chain
  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    logic [INDEX_BITS-1:0] prev_start, prev_end, next_start, next_end;

    if (k == 0) begin : g_head
      assign prev_start = pend_start_r;
      assign prev_end   = pend_end_r;
    end else begin : g_body
      assign prev_start = cell_start[k-1];
      assign prev_end   = cell_end[k-1];
    end

    if (k == TABLE_DEPTH - 1) begin : g_tail
      assign next_start = cell_start[k];
      assign next_end   = cell_end[k];
    end else begin : g_mid
      assign next_start = cell_start[k+1];
      assign next_end   = cell_end[k+1];
    end

    assign cell_valid[k] = (CNT_W'(k) < count_r);

    isms_cell #(
      .IDX_W (INDEX_BITS)
    ) u_cell (
      .clk          (clk),
      .valid_i      (cell_valid[k]),
      .op_i         (cell_op[k]),
      .new_start_i  (pend_start_r),
      .new_end_i    (pend_end_r),
      .prev_start_i (prev_start),
      .prev_end_i   (prev_end),
      .next_start_i (next_start),
      .next_end_i   (next_end),
      .start_o      (cell_start[k]),
      .end_o        (cell_end[k]),
      .flags_o      (cell_flags[k])
    );
  end

  // overlapping cells form one contiguous run; pick its head
  always_comb begin
    sel_start = '0;
    sel_end   = '0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      overlap[k] = cell_valid[k] && !cell_flags[k].low && !cell_flags[k].high;
    end
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (k == 0) begin
        first_ov[k] = overlap[k];
      end else begin
        first_ov[k] = overlap[k] && !overlap[k-1];
      end
      sel_start = sel_start | (first_ov[k] ? cell_start[k] : '0);
      sel_end   = sel_end   | (first_ov[k] ? cell_end[k]   : '0);
    end
  end

  // ---------------------------------------------------------------- control
  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign range_bad  = (pend_end_r < pend_start_r);
  assign any_ov     = |overlap;
  assign table_full = (count_r == CNT_W'(TABLE_DEPTH));

  assign remove_step = (state_r == S_BUSY) && (mode_r == MODE_INSERT) && !range_bad && any_ov;
  assign res_ready   = (mode_r == MODE_READ) || range_bad || !any_ov;
  assign commit      = (state_r == S_BUSY) && res_ready && out_free;
  assign do_insert   = commit && (mode_r == MODE_INSERT) && !range_bad && !table_full;

  always_comb begin
    if (mode_r == MODE_READ) begin
      res_status = ST_DONE;
    end else if (range_bad) begin
      res_status = ST_INVALID;
    end else if (table_full) begin
      res_status = ST_FULL;
    end else begin
      res_status = ST_DONE;
    end
  end

  // drop one absorbed range per cycle, or open the sorted slot for the new one
  always_comb begin
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      cell_op[k] = CELL_HOLD;
      if (remove_step) begin
        if (cell_valid[k] && !cell_flags[k].low) begin
          cell_op[k] = CELL_TAKE_NEXT;
        end
      end else if (do_insert) begin
        if (cell_valid[k] && cell_flags[k].low) begin
          cell_op[k] = CELL_HOLD;
        end else if (k == 0) begin
          cell_op[k] = CELL_LOAD_NEW;
        end else if (cell_valid[k-1] && cell_flags[k-1].low) begin
          cell_op[k] = CELL_LOAD_NEW;
        end else begin
          cell_op[k] = CELL_TAKE_PREV;
        end
      end
    end
  end

  assign rd_hit   = (mode_r == MODE_READ) && (CNT_W'(ridx_r) < count_r);
  assign rd_start = rd_hit ? cell_start[ridx_r] : '0;
  assign rd_end   = rd_hit ? cell_end[ridx_r]   : '0;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    mode_nxt       = mode_r;
    pend_start_nxt = pend_start_r;
    pend_end_nxt   = pend_end_r;
    ridx_nxt       = ridx_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          mode_nxt       = in_tuser;
          pend_start_nxt = in_tdata[INDEX_BITS-1:0];
          pend_end_nxt   = in_tdata[2*INDEX_BITS-1:INDEX_BITS];
          ridx_nxt       = in_tdata[2*INDEX_BITS+RIDX_W-1:2*INDEX_BITS];
          state_nxt      = S_BUSY;
        end
      end
      S_BUSY: begin
        if (remove_step) begin
          // widen the pending range by the absorbed one
          pend_start_nxt = (sel_start < pend_start_r) ? sel_start : pend_start_r;
          pend_end_nxt   = (sel_end > pend_end_r) ? sel_end : pend_end_r;
          count_nxt      = count_r - CNT_W'(1);
        end else if (commit) begin
          if (do_insert) begin
            count_nxt = count_r + CNT_W'(1);
          end
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = OUT_TD_W'({rd_end, rd_start, rd_hit,
                                      (do_insert ? count_r + CNT_W'(1) : count_r),
                                      res_status});
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    out_tdata_r  <= out_tdata_nxt;
    mode_r       <= mode_nxt;
    pend_start_r <= pend_start_nxt;
    pend_end_r   <= pend_end_nxt;
    ridx_r       <= ridx_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // ---------------------------------------------------------------- checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_one_overlap_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BUSY) && (mode_r == MODE_INSERT) && !range_bad |-> $onehot0(first_ov))
    else $error("overlapping entries not contiguous");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    remove_step |=> (count_r + CNT_W'(1)) == $past(count_r))
    else $error("absorb step did not drop one entry");

  a_full_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    commit && (res_status == ST_FULL) |=> $stable(count_r))
    else $error("dropped insert changed the table");

  a_result_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_tvalid_r && (state_r == S_IDLE))
    else $error("finished word not presented");

endmodule

`default_nettype wire

// ===== rtl/isms_cell.sv =====
// One table slot of the range chain: holds a range, compares it, shifts with neighbors.
`timescale 1ns / 1ps
`default_nettype none

module isms_cell import isms_pkg::*; #(
  parameter int IDX_W = 31
) (
  input  wire logic             clk,
  input  wire logic             valid_i,
  input  wire cell_op_t         op_i,
  input  wire logic [IDX_W-1:0] new_start_i,
  input  wire logic [IDX_W-1:0] new_end_i,
  input  wire logic [IDX_W-1:0] prev_start_i,
  input  wire logic [IDX_W-1:0] prev_end_i,
  input  wire logic [IDX_W-1:0] next_start_i,
  input  wire logic [IDX_W-1:0] next_end_i,
  output logic      [IDX_W-1:0] start_o,
  output logic      [IDX_W-1:0] end_o,
  output cell_flags_t           flags_o
);

  logic [IDX_W-1:0] start_r, start_nxt;
  logic [IDX_W-1:0] end_r, end_nxt;

  always_comb begin
    start_nxt = start_r;
    end_nxt   = end_r;
    case (op_i)
      CELL_HOLD: begin
        start_nxt = start_r;
        end_nxt   = end_r;
      end
      CELL_LOAD_NEW: begin
        start_nxt = new_start_i;
        end_nxt   = new_end_i;
      end
      CELL_TAKE_PREV: begin
        start_nxt = prev_start_i;
        end_nxt   = prev_end_i;
      end
      CELL_TAKE_NEXT: begin
        start_nxt = next_start_i;
        end_nxt   = next_end_i;
      end
      default: begin
        start_nxt = start_r;
        end_nxt   = end_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    end_r   <= end_nxt;
  end

  // touching ranges stay apart: strict compares
  assign flags_o.low  = valid_i && (end_r < new_start_i);
  assign flags_o.high = valid_i && (new_end_i < start_r);
  assign start_o      = start_r;
  assign end_o        = end_r;

endmodule

`default_nettype wire

// ===== tb/sv/isms_result_checker.sv =====
// Predicts and checks every result word of the interval set merge/insert block.
`timescale 1ns / 1ps

module isms_result_checker import isms_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  // low to high: range_start, range_end, read_index
  input  logic [71:0] in_tdata,
  // mode
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  // low to high: status, entry_count, entry_valid, entry_start, entry_end
  input  logic [71:0] out_tdata,
  output int          error_count,
  output int          results_pending
);

  localparam int TABLE_DEPTH = 16;

  typedef struct packed {
    status_t     status;
    logic [4:0]  count;
    logic        valid;
    logic [30:0] lo;
    logic [30:0] hi;
  } range_result_t;

  // Shadow copy of the range table
  logic [30:0]   span_lo [TABLE_DEPTH];
  logic [30:0]   span_hi [TABLE_DEPTH];
  int            span_count;
  range_result_t predicted_words[$];

  initial error_count = 0;

  function automatic range_result_t apply_range_word(logic mode, logic [30:0] ns,
                                                     logic [30:0] ne, logic [3:0] idx);
    range_result_t r;
    logic [30:0]   lo_n [TABLE_DEPTH];
    logic [30:0]   hi_n [TABLE_DEPTH];
    logic [30:0]   mlo;
    logic [30:0]   mhi;
    int            absorbed;
    int            n_new;
    bit            placed;
    r = '0;
    r.status = ST_DONE;
    if (mode == MODE_READ) begin
      if (idx < span_count) begin
        r.valid = 1'b1;
        r.lo    = span_lo[idx];
        r.hi    = span_hi[idx];
      end
    end else if (ne < ns) begin
      r.status = ST_INVALID;
    end else begin
      // widen the new range over every stored range it overlaps
      mlo = ns;
      mhi = ne;
      absorbed = 0;
      for (int k = 0; k < span_count; k++) begin
        if (span_lo[k] <= ne && span_hi[k] >= ns) begin
          absorbed++;
          if (span_lo[k] < mlo) mlo = span_lo[k];
          if (span_hi[k] > mhi) mhi = span_hi[k];
        end
      end
      if (absorbed == 0 && span_count == TABLE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        n_new = 0;
        placed = 1'b0;
        for (int k = 0; k < span_count; k++) begin
          if (span_hi[k] < ns) begin
            lo_n[n_new] = span_lo[k];
            hi_n[n_new] = span_hi[k];
            n_new++;
          end else if (span_lo[k] > ne) begin
            if (!placed) begin
              lo_n[n_new] = mlo;
              hi_n[n_new] = mhi;
              n_new++;
              placed = 1'b1;
            end
            lo_n[n_new] = span_lo[k];
            hi_n[n_new] = span_hi[k];
            n_new++;
          end
        end
        if (!placed) begin
          lo_n[n_new] = mlo;
          hi_n[n_new] = mhi;
          n_new++;
        end
        for (int k = 0; k < n_new; k++) begin
          span_lo[k] = lo_n[k];
          span_hi[k] = hi_n[k];
        end
        span_count = n_new;
      end
    end
    r.count = 5'(span_count);
    return r;
  endfunction

  task automatic check_field(string field, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    range_result_t want;
    if (!rst_n) begin
      span_count = 0;
      predicted_words.delete();
    end else begin
      // compare first: a word leaving now belongs to an older input
      if (out_tvalid && out_tready) begin
        if (predicted_words.size() == 0) begin
          $display("%0t: result word with nothing expected, actual %h", $time, out_tdata);
          error_count++;
        end else begin
          want = predicted_words.pop_front();
          check_field("status", want.status, out_tdata[1:0]);
          check_field("entry_count", want.count, out_tdata[6:2]);
          check_field("entry_valid", want.valid, out_tdata[7]);
          check_field("entry_start", want.lo, out_tdata[38:8]);
          check_field("entry_end", want.hi, out_tdata[69:39]);
        end
      end
      if (in_tvalid && in_tready)
        predicted_words.push_back(apply_range_word(in_tuser, in_tdata[30:0],
                                                   in_tdata[61:31], in_tdata[65:62]));
    end
    results_pending <= predicted_words.size();
  end

endmodule

// ===== tb/sv/interval_set_merge_insert_tb.sv =====
// Stimulus and verdict for the interval set merge/insert block.
`timescale 1ns / 1ps

module interval_set_merge_insert_tb;
  import isms_pkg::*;

  localparam logic [30:0] MAX_IDX    = 31'h7FFF_FFFF;
  localparam int          IDLE_LIMIT = 2000;
  localparam int          PHASE_WORDS = 417;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        in_tuser = MODE_INSERT;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;

  int          error_count;
  int          results_pending;
  int          gap_pct = 10;
  int          stall_pct = 61;
  int          idle_cycles = 0;
  logic [30:0] cluster_base;
  logic [30:0] recent_bases [4];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  interval_set_merge_insert u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  isms_result_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .error_count    (error_count),
    .results_pending(results_pending)
  );

  always @(posedge clk) out_tready <= ($urandom_range(0, 99) >= stall_pct);

  // Abort when neither channel moves a word for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_word(logic mode, logic [30:0] s, logic [30:0] e, logic [3:0] idx);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {6'b0, idx, e, s};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic insert_range(logic [30:0] s, logic [30:0] e);
    send_word(MODE_INSERT, s, e, 4'($urandom()));
  endtask

  task automatic read_entry(logic [3:0] idx);
    send_word(MODE_READ, 31'($urandom()), 31'($urandom()), idx);
  endtask

  // Hold the sender until every result has drained
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
  endtask

  task automatic random_word(int n);
    int unsigned pick;
    int unsigned len;
    int unsigned s;
    int unsigned e;
    if (n % 40 == 0) begin
      recent_bases[$urandom_range(0, 3)] = cluster_base;
      if ($urandom_range(0, 1) == 0) cluster_base = recent_bases[$urandom_range(0, 3)];
      else if ($urandom_range(0, 9) == 0) cluster_base = MAX_IDX - 31'd63;
      else cluster_base = 31'($urandom_range(0, 32'h7FFF_FF00));
    end
    pick = $urandom_range(0, 99);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 80) : $urandom_range(0, 7);
    if (pick < 25) begin
      read_entry(4'($urandom()));
    end else if (pick < 80) begin
      // dense inserts in a small window: touching, overlapping, merging
      s = cluster_base + $urandom_range(0, 63);
      e = s + len;
      insert_range(31'(s), (e > MAX_IDX) ? MAX_IDX : 31'(e));
    end else if (pick < 90) begin
      s = $urandom() & MAX_IDX;
      e = s + $urandom_range(0, 7);
      insert_range(31'(s), (e > MAX_IDX) ? MAX_IDX : 31'(e));
    end else begin
      insert_range(31'($urandom()), 31'($urandom()));
    end
  endtask

  initial begin
    cluster_base = 31'($urandom_range(0, 32'h7FFF_FF00));
    foreach (recent_bases[k]) recent_bases[k] = cluster_base;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty reads, invalid range, extremes, touching, multi-merge
    read_entry(4'd15);
    insert_range(31'd9, 31'd8);
    insert_range(31'd0, 31'd0);
    insert_range(MAX_IDX, MAX_IDX);
    insert_range(31'd1, 31'd1);
    insert_range(31'd10, 31'd12);
    insert_range(31'd20, 31'd22);
    insert_range(31'd30, 31'd32);
    insert_range(31'd11, 31'd31);
    read_entry(4'd2);
    // fill the table, then drop a disjoint range and merge while full
    for (int k = 0; k < 12; k++) insert_range(31'(100 + 10 * k), 31'(101 + 10 * k));
    insert_range(31'd5, 31'd5);
    insert_range(31'd0, 31'd1);
    read_entry(4'd15);
    drain_results();

    for (int n = 0; n < PHASE_WORDS; n++) random_word(n);
    drain_results();

    gap_pct = 61;
    stall_pct = 10;
    for (int n = 0; n < PHASE_WORDS; n++) random_word(n);
    drain_results();

    gap_pct = 0;
    stall_pct = 0;
    for (int n = 0; n < PHASE_WORDS; n++) random_word(n);
    drain_results();

    repeat (40) @(posedge clk);
    if (error_count == 0 && results_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/isms_pkg.sv
rtl/isms_cell.sv
rtl/interval_set_merge_insert.sv
tb/sv/isms_result_checker.sv
tb/sv/interval_set_merge_insert_tb.sv
